### rtl/hddc_pkg.sv
// shared types, codes and helpers of the heading and distance drive controller
// no dependencies; imported by every rtl module of the block
package hddc_pkg;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_HEADING_OFFSET  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_HEADING_BAND    = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_DISTANCE_TARGET = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_DISTANCE_BAND   = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_CORRECT_ENABLE  = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_TURN_ANGLE      = 3'd5;

	localparam logic [1:0] FUNC_SAMPLE   = 2'd0;
	localparam logic [1:0] FUNC_APPROACH = 2'd1;
	localparam logic [1:0] FUNC_TURN     = 2'd2;

	localparam logic signed [1:0] DRIVE_REV  = -2'sd1;
	localparam logic signed [1:0] DRIVE_STOP = 2'sd0;
	localparam logic signed [1:0] DRIVE_FWD  = 2'sd1;

	localparam logic signed [11:0] DEG_360 = 12'sd360;
	localparam logic signed [11:0] DEG_720 = 12'sd720;

	typedef enum logic [1:0] {
		MODE_IDLE     = 2'd0,
		MODE_APPROACH = 2'd1,
		MODE_TURN     = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		WRAP_NONE  = 2'd0,
		WRAP_BELOW = 2'd1,
		WRAP_ABOVE = 2'd2
	} wrap_t;

	typedef struct packed {
		logic signed [9:0] heading_offset;
		logic [6:0]        heading_band;
		logic [15:0]       distance_target;
		logic [11:0]       distance_band;
		logic              correct_enable;
		logic signed [9:0] turn_angle;
	} cfg_t;

	typedef struct packed {
		logic signed [1:0] left_drive;
		logic signed [1:0] right_drive;
		mode_t             mode;
		logic              done;
	} step_res_t;

	// wraps any value in -720..1079 into 0..359
	function automatic logic [8:0] wrap360(input logic signed [11:0] v);
		logic signed [11:0] r;
		if (v < -DEG_360) begin
			r = v + DEG_720;
		end else if (v < 12'sd0) begin
			r = v + DEG_360;
		end else if (v < DEG_360) begin
			r = v;
		end else if (v < DEG_720) begin
			r = v - DEG_360;
		end else begin
			r = v - DEG_720;
		end
		return r[8:0];
	endfunction

endpackage

### rtl/heading_distance_drive_controller.sv
// Two-wheel heading and distance drive controller, top level.
// Request channel: in_valid / in_stall carry func, compass_raw, distance and
// distance_valid. Result channel: out_valid / out_stall carry the wheel
// commands, the wrapped heading, the deviation from the target heading, the
// mode after the request and done_res. Every request gives one result.
// Config: cfg_we writes cfg_data into the register at cfg_index (0 heading
// offset, 1 heading band, 2 distance target, 3 distance band, 4 correct
// enable, 5 turn angle); write only while no request is in flight.
// Path: a request taken at an edge is held in the input register, and its
// result is loaded from there into the output register, where out_valid
// rises. Throughput is one request per cycle while out_stall is low: the
// input register feeds one pass of wrap, compare and select logic that also
// updates the controller state in that same cycle.
// A stalled result holds in the output register; one more request waits in
// the input register, after which in_stall is raised until out_stall drops.
// Reset clears the valid flags of both registers, restores the register defaults, stops the
// wheels and leaves the controller idle with the turn armed.
module heading_distance_drive_controller #(
	parameter int DISTANCE_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [1:0]                       func,
	input  logic [8:0]                       compass_raw,
	input  logic [15:0]                      distance,
	input  logic                             distance_valid,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [1:0]                left_drive,
	output logic signed [1:0]                right_drive,
	output logic [8:0]                       heading,
	output logic signed [8:0]                deviation,
	output logic [1:0]                       mode,
	output logic                             done_res,
	input  logic                             cfg_we,
	input  logic [hddc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [hddc_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import hddc_pkg::*;

	cfg_t      cfg;
	step_res_t res;

	logic              valid_s1;
	logic [1:0]        func_s1;
	logic [8:0]        compass_s1;
	logic [15:0]       distance_s1;
	logic              dist_valid_s1;

	logic              valid_s2;
	logic signed [1:0] left_s2, right_s2;
	logic [8:0]        heading_s2;
	logic signed [8:0] deviation_s2;
	mode_t             mode_s2;
	logic              done_s2;

	logic              advance, step_en;
	logic [8:0]        target_heading;
	logic [8:0]        heading_c;
	logic signed [8:0] deviation_c;

	assign advance  = !valid_s2 || !out_stall;
	assign step_en  = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	hddc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	hddc_heading u_heading (
		.compass_raw    (compass_s1),
		.heading_offset (cfg.heading_offset),
		.target_heading (target_heading),
		.heading        (heading_c),
		.deviation      (deviation_c)
	);

	hddc_ctrl #(
		.DISTANCE_BITS (DISTANCE_BITS)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.step_en        (step_en),
		.cfg            (cfg),
		.func           (func_s1),
		.distance       (distance_s1),
		.distance_valid (dist_valid_s1),
		.heading        (heading_c),
		.deviation      (deviation_c),
		.target_heading (target_heading),
		.res            (res)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			func_s1       <= func;
			compass_s1    <= compass_raw;
			distance_s1   <= distance;
			dist_valid_s1 <= distance_valid;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			left_s2      <= res.left_drive;
			right_s2     <= res.right_drive;
			heading_s2   <= heading_c;
			deviation_s2 <= deviation_c;
			mode_s2      <= res.mode;
			done_s2      <= res.done;
		end
	end

	assign out_valid   = valid_s2;
	assign left_drive  = left_s2;
	assign right_drive = right_s2;
	assign heading     = heading_s2;
	assign deviation   = deviation_s2;
	assign mode        = mode_s2;
	assign done_res    = done_s2;

endmodule

### rtl/hddc_cfg_regs.sv
// configuration register bank of the drive controller
// depends on hddc_pkg for register indexes and the config struct
module hddc_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [hddc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [hddc_pkg::CFG_DATA_W-1:0]  cfg_data,
	output hddc_pkg::cfg_t                   cfg
);
	import hddc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.heading_offset  <= 10'sd0;
			cfg_q.heading_band    <= 7'd5;
			cfg_q.distance_target <= 16'd160;
			cfg_q.distance_band   <= 12'd13;
			cfg_q.correct_enable  <= 1'b0;
			cfg_q.turn_angle      <= 10'sd180;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HEADING_OFFSET:  cfg_q.heading_offset  <= cfg_data[9:0];
				REG_HEADING_BAND:    cfg_q.heading_band    <= cfg_data[6:0];
				REG_DISTANCE_TARGET: cfg_q.distance_target <= cfg_data[15:0];
				REG_DISTANCE_BAND:   cfg_q.distance_band   <= cfg_data[11:0];
				REG_CORRECT_ENABLE:  cfg_q.correct_enable  <= cfg_data[0];
				REG_TURN_ANGLE:      cfg_q.turn_angle      <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### rtl/hddc_heading.sv
// heading path: offset and wrap of the raw compass value, shortest deviation
// from the stored target heading; purely combinational, uses hddc_pkg
module hddc_heading (
	input  logic [8:0]        compass_raw,
	input  logic signed [9:0] heading_offset,
	input  logic [8:0]        target_heading,
	output logic [8:0]        heading,
	output logic signed [8:0] deviation
);
	import hddc_pkg::*;

	logic signed [11:0] sum;
	logic signed [9:0]  diff;
	logic signed [9:0]  diff_adj;

	assign sum     = {3'b000, compass_raw} + {{2{heading_offset[9]}}, heading_offset};
	assign heading = wrap360(sum);
	assign diff    = {1'b0, target_heading} - {1'b0, heading};

	always_comb begin
		if (diff >= -10'sd180 && diff <= 10'sd180) begin
			diff_adj = diff;
		end else if (diff > 10'sd0) begin
			diff_adj = diff - 10'sd360;
		end else begin
			diff_adj = diff + 10'sd360;
		end
	end

	assign deviation = diff_adj[8:0];

endmodule

### rtl/hddc_ctrl.sv
// drive sequencer: mode state, distance latch, turn target and wheel commands
// state advances once per request on step_en; uses hddc_pkg
module hddc_ctrl #(
	parameter int DISTANCE_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step_en,
	input  hddc_pkg::cfg_t       cfg,
	input  logic [1:0]           func,
	input  logic [15:0]          distance,
	input  logic                 distance_valid,
	input  logic [8:0]           heading,
	input  logic signed [8:0]    deviation,
	output logic [8:0]           target_heading,
	output hddc_pkg::step_res_t  res
);
	import hddc_pkg::*;

	localparam int CW = (DISTANCE_BITS > 16 ? DISTANCE_BITS : 16) + 1;

	mode_t                    mode_q, mode_n;
	wrap_t                    wrap_q, wrap_n;
	logic [8:0]               target_q, target_n;
	logic                     armed_q, armed_n;
	logic                     reached_q, reached_n;
	logic [DISTANCE_BITS-1:0] dist_q, dist_n;
	logic signed [1:0]        left_q, left_n, right_q, right_n;
	logic                     step_done;

	logic signed [11:0] turn_sum;
	logic [CW-1:0]      dist_ext, tgt_ext, db_ext;
	logic               too_far, too_near;
	logic signed [8:0]  band_s;
	logic [9:0]         tgt_plus_band, head_plus_band;
	logic               angle_pos;

	assign turn_sum  = {3'b000, heading} + {{2{cfg.turn_angle[9]}}, cfg.turn_angle};
	assign dist_n    = distance_valid ? DISTANCE_BITS'(distance) : dist_q;
	assign dist_ext  = CW'(dist_n);
	assign tgt_ext   = CW'(cfg.distance_target);
	assign db_ext    = CW'(cfg.distance_band);
	assign too_far   = dist_ext > tgt_ext + db_ext;
	assign too_near  = dist_ext + db_ext < tgt_ext;
	assign band_s    = {2'b00, cfg.heading_band};
	assign angle_pos = !cfg.turn_angle[9] && (cfg.turn_angle != 10'sd0);
	assign head_plus_band = {1'b0, heading} + {3'b000, cfg.heading_band};
	assign tgt_plus_band  = {1'b0, target_n} + {3'b000, cfg.heading_band};

	// next state
	always_comb begin
		mode_n    = mode_q;
		wrap_n    = wrap_q;
		target_n  = target_q;
		armed_n   = armed_q;
		reached_n = reached_q;
		left_n    = left_q;
		right_n   = right_q;
		step_done = 1'b0;

		if (func == FUNC_APPROACH || func == FUNC_TURN) begin
			mode_n    = mode_t'(func);
			armed_n   = 1'b1;
			reached_n = 1'b0;
		end

		case (mode_n)
			MODE_APPROACH: begin
				if (!too_far && !too_near) begin
					left_n    = DRIVE_STOP;
					right_n   = DRIVE_STOP;
					mode_n    = MODE_IDLE;
					step_done = 1'b1;
				end else if (cfg.correct_enable && deviation > band_s) begin
					left_n  = DRIVE_FWD;
					right_n = DRIVE_REV;
				end else if (cfg.correct_enable && deviation < -band_s) begin
					left_n  = DRIVE_REV;
					right_n = DRIVE_FWD;
				end else begin
					left_n  = too_far ? DRIVE_FWD : DRIVE_REV;
					right_n = too_far ? DRIVE_FWD : DRIVE_REV;
				end
			end
			MODE_TURN: begin
				if (armed_n) begin
					if (turn_sum < 12'sd0) begin
						wrap_n = WRAP_BELOW;
					end else if (turn_sum > 12'sd359) begin
						wrap_n = WRAP_ABOVE;
					end else begin
						wrap_n = WRAP_NONE;
					end
					target_n  = wrap360(turn_sum);
					armed_n   = 1'b0;
					reached_n = 1'b0;
				end
				if (!reached_n) begin
					case (wrap_n)
						WRAP_BELOW: begin
							if (heading < target_n || {1'b0, heading} > tgt_plus_band) begin
								left_n  = DRIVE_REV;
								right_n = DRIVE_FWD;
							end else begin
								reached_n = 1'b1;
							end
						end
						WRAP_ABOVE: begin
							// heading < target - band, kept unsigned
							if (heading > target_n || head_plus_band < {1'b0, target_n}) begin
								left_n  = DRIVE_FWD;
								right_n = DRIVE_REV;
							end else begin
								reached_n = 1'b1;
							end
						end
						default: begin
							if (angle_pos) begin
								if (heading < target_n) begin
									left_n  = DRIVE_FWD;
									right_n = DRIVE_REV;
								end else begin
									reached_n = 1'b1;
								end
							end else begin
								if (heading > target_n) begin
									left_n  = DRIVE_REV;
									right_n = DRIVE_FWD;
								end else begin
									reached_n = 1'b1;
								end
							end
						end
					endcase
				end else begin
					// wheels ran one more request after reaching, now stop
					reached_n = 1'b0;
					armed_n   = 1'b1;
					target_n  = 9'd0;
					mode_n    = MODE_IDLE;
					left_n    = DRIVE_STOP;
					right_n   = DRIVE_STOP;
					step_done = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// outputs
	always_comb begin
		res.left_drive  = left_n;
		res.right_drive = right_n;
		res.mode        = mode_n;
		res.done        = step_done;
	end

	assign target_heading = target_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_IDLE;
			wrap_q    <= WRAP_NONE;
			target_q  <= 9'd0;
			armed_q   <= 1'b1;
			reached_q <= 1'b0;
			dist_q    <= '0;
			left_q    <= DRIVE_STOP;
			right_q   <= DRIVE_STOP;
		end else if (step_en) begin
			mode_q    <= mode_n;
			wrap_q    <= wrap_n;
			target_q  <= target_n;
			armed_q   <= armed_n;
			reached_q <= reached_n;
			dist_q    <= dist_n;
			left_q    <= left_n;
			right_q   <= right_n;
		end
	end

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// self-checking testbench for heading_distance_drive_controller: directed and random requests,
// a scoreboard class predicts every result; depends on rtl/hddc_pkg.sv and the top level rtl
module tb;
	import hddc_pkg::*;

	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES = 80;
	localparam int PHASE_REQUESTS = 200;
	localparam int RANDOM_PHASES = 8;

	typedef struct {
		logic signed [1:0] left_drive;
		logic signed [1:0] right_drive;
		logic [8:0]        heading;
		logic signed [8:0] deviation;
		logic [1:0]        mode;
		logic              done;
	} drive_res_t;

	class drive_scoreboard;
		int head_offset;
		int head_band;
		int dist_target;
		int dist_band;
		bit correct_on;
		int turn_deg;
		mode_t run_mode;
		wrap_t wrap_dir;
		int target_heading;
		int stored_distance;
		bit turn_armed;
		bit turn_reached;
		logic signed [1:0] left_cmd;
		logic signed [1:0] right_cmd;
		int last_heading;
		drive_res_t expected_q[$];
		int n_errors;
		int n_checked;
		int n_done;

		function new();
			head_offset = 0;
			head_band = 5;
			dist_target = 160;
			dist_band = 13;
			correct_on = 1'b0;
			turn_deg = 180;
			run_mode = MODE_IDLE;
			wrap_dir = WRAP_NONE;
			target_heading = 0;
			stored_distance = 0;
			turn_armed = 1'b1;
			turn_reached = 1'b0;
			left_cmd = DRIVE_STOP;
			right_cmd = DRIVE_STOP;
			last_heading = 0;
		endfunction

		function int wrap_deg(int v);
			int r;
			r = v % 360;
			if (r < 0) begin
				r += 360;
			end
			return r;
		endfunction

		function void set_wheels(logic signed [1:0] l, logic signed [1:0] r);
			left_cmd = l;
			right_cmd = r;
		endfunction

		function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_HEADING_OFFSET: head_offset = int'($signed(data[9:0]));
				REG_HEADING_BAND: head_band = int'(data[6:0]);
				REG_DISTANCE_TARGET: dist_target = int'(data);
				REG_DISTANCE_BAND: dist_band = int'(data[11:0]);
				REG_CORRECT_ENABLE: correct_on = data[0];
				REG_TURN_ANGLE: turn_deg = int'($signed(data[9:0]));
				default: ;
			endcase
		endfunction

		// one accepted request: advance the controller state and queue its result
		function void note_request(logic [1:0] fn, logic [8:0] raw, logic [15:0] dist_val,
				logic dv);
			int h;
			int d;
			int dev;
			int t;
			logic signed [1:0] dir;
			bit done;
			drive_res_t r;
			h = wrap_deg(int'(raw) + head_offset);
			d = target_heading - h;
			if (d > 180) begin
				dev = d - 360;
			end else if (d < -180) begin
				dev = d + 360;
			end else begin
				dev = d;
			end
			done = 1'b0;
			if (dv) begin
				stored_distance = int'(dist_val);
			end
			if (fn == FUNC_APPROACH || fn == FUNC_TURN) begin
				run_mode = mode_t'(fn);
				turn_armed = 1'b1;
				turn_reached = 1'b0;
			end
			case (run_mode)
				MODE_APPROACH: begin
					if (stored_distance > dist_target + dist_band) begin
						dir = DRIVE_FWD;
					end else if (stored_distance < dist_target - dist_band) begin
						dir = DRIVE_REV;
					end else begin
						dir = DRIVE_STOP;
					end
					if (dir == DRIVE_STOP) begin
						set_wheels(DRIVE_STOP, DRIVE_STOP);
						run_mode = MODE_IDLE;
						done = 1'b1;
					end else if (correct_on && dev > head_band) begin
						set_wheels(DRIVE_FWD, DRIVE_REV);
					end else if (correct_on && dev < -head_band) begin
						set_wheels(DRIVE_REV, DRIVE_FWD);
					end else begin
						set_wheels(dir, dir);
					end
				end
				MODE_TURN: begin
					if (turn_armed) begin
						t = h + turn_deg;
						if (t < 0) begin
							wrap_dir = WRAP_BELOW;
						end else if (t > 359) begin
							wrap_dir = WRAP_ABOVE;
						end else begin
							wrap_dir = WRAP_NONE;
						end
						target_heading = wrap_deg(t);
						turn_armed = 1'b0;
						turn_reached = 1'b0;
					end
					if (!turn_reached) begin
						t = target_heading;
						case (wrap_dir)
							WRAP_BELOW: begin
								if (h < t || h > t + head_band) begin
									set_wheels(DRIVE_REV, DRIVE_FWD);
								end else begin
									turn_reached = 1'b1;
								end
							end
							WRAP_ABOVE: begin
								if (h > t || h < t - head_band) begin
									set_wheels(DRIVE_FWD, DRIVE_REV);
								end else begin
									turn_reached = 1'b1;
								end
							end
							default: begin
								if (turn_deg > 0) begin
									if (h < t) begin
										set_wheels(DRIVE_FWD, DRIVE_REV);
									end else begin
										turn_reached = 1'b1;
									end
								end else if (h > t) begin
									set_wheels(DRIVE_REV, DRIVE_FWD);
								end else begin
									turn_reached = 1'b1;
								end
							end
						endcase
					end else begin
						// target was reached on the previous request: stop and rearm
						turn_reached = 1'b0;
						turn_armed = 1'b1;
						target_heading = 0;
						run_mode = MODE_IDLE;
						set_wheels(DRIVE_STOP, DRIVE_STOP);
						done = 1'b1;
					end
				end
				default: ;
			endcase
			r.left_drive = left_cmd;
			r.right_drive = right_cmd;
			r.heading = 9'(h);
			r.deviation = 9'(dev);
			r.mode = run_mode;
			r.done = done;
			expected_q.push_back(r);
			last_heading = h;
			if (done) begin
				n_done++;
			end
		endfunction

		function bit field_ok(string name, int want, int got);
			if (want != got) begin
				$display("%0t: %s expected %0d got %0d", $time, name, want, got);
				return 1'b0;
			end
			return 1'b1;
		endfunction

		function void check_result(drive_res_t got);
			drive_res_t want;
			bit ok;
			if (expected_q.size() == 0) begin
				$display("%0t: result with none expected: left %0d right %0d heading %0d",
					$time, got.left_drive, got.right_drive, got.heading);
				$display("%0t: dev %0d mode %0d done %0d", $time, got.deviation, got.mode,
					got.done);
				n_errors++;
				return;
			end
			want = expected_q.pop_front();
			n_checked++;
			ok = 1'b1;
			if ($isunknown({got.left_drive, got.right_drive, got.heading, got.deviation, got.mode,
					got.done})) begin
				$display("%0t: result has unknown bits, expected heading %0d got %b", $time,
					want.heading, got.heading);
				ok = 1'b0;
			end
			ok &= field_ok("left_drive", want.left_drive, got.left_drive);
			ok &= field_ok("right_drive", want.right_drive, got.right_drive);
			ok &= field_ok("heading", want.heading, got.heading);
			ok &= field_ok("deviation", want.deviation, got.deviation);
			ok &= field_ok("mode", want.mode, got.mode);
			ok &= field_ok("done_res", want.done, got.done);
			if (!ok) begin
				n_errors++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] func = FUNC_SAMPLE;
	logic [8:0] compass_raw = '0;
	logic [15:0] distance = '0;
	logic distance_valid = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [1:0] left_drive;
	logic signed [1:0] right_drive;
	logic [8:0] heading;
	logic signed [8:0] deviation;
	logic [1:0] mode;
	logic done_res;
	logic cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = REG_HEADING_OFFSET;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	drive_scoreboard sb = new();
	drive_res_t seen;
	bit calm = 1'b0;
	bit hold_off = 1'b0;
	int n_requests = 0;
	int n_settings = 0;
	int idle_cycles = 0;

	heading_distance_drive_controller i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.compass_raw(compass_raw),
		.distance(distance),
		.distance_valid(distance_valid),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.left_drive(left_drive),
		.right_drive(right_drive),
		.heading(heading),
		.deviation(deviation),
		.mode(mode),
		.done_res(done_res),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [8:0] rand_raw();
		if ($urandom_range(9) == 0) begin
			return 9'($urandom_range(511));
		end
		return 9'($urandom_range(359));
	endfunction

	task automatic send_request(input logic [1:0] fn, input logic [8:0] raw,
			input logic [15:0] dist_val, input logic dv);
		int gap;
		if (!calm && $urandom_range(99) < 20) begin
			in_valid <= 1'b0;
			gap = $urandom_range(3, 1);
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= fn;
		compass_raw <= raw;
		distance <= dist_val;
		distance_valid <= dv;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_request(fn, raw, dist_val, dv);
		n_requests++;
	endtask

	// stop offering and wait until every queued result has come back
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic program_regs(input int off, input int band, input int tgt, input int dband,
			input int corr, input int turn);
		logic [CFG_INDEX_W-1:0] regs[6];
		int vals[6];
		regs = '{REG_HEADING_OFFSET, REG_HEADING_BAND, REG_DISTANCE_TARGET, REG_DISTANCE_BAND,
			REG_CORRECT_ENABLE, REG_TURN_ANGLE};
		vals = '{off, band, tgt, dband, corr, turn};
		for (int i = 0; i < 6; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= regs[i];
			cfg_data <= CFG_DATA_W'(vals[i]);
			@(posedge clk);
			sb.set_reg(regs[i], CFG_DATA_W'(vals[i]));
		end
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	task automatic run_directed();
		// default settings: target 160, band 13, turn 180
		send_request(FUNC_SAMPLE, 9'd0, 16'd0, 1'b1);
		send_request(FUNC_UNUSED, 9'h1FF, 16'hFFFF, 1'b0);
		send_request(FUNC_APPROACH, 9'd90, 16'd300, 1'b1);
		send_request(FUNC_SAMPLE, 9'd90, 16'd165, 1'b1);
		send_request(FUNC_APPROACH, 9'd90, 16'd100, 1'b1);
		send_request(FUNC_SAMPLE, 9'd90, 16'd0, 1'b0);
		send_request(FUNC_SAMPLE, 9'd90, 16'd160, 1'b1);
		// turn past 359, then reach inside the band
		send_request(FUNC_TURN, 9'd270, 16'd0, 1'b0);
		send_request(FUNC_SAMPLE, 9'd88, 16'd0, 1'b0);
		send_request(FUNC_SAMPLE, 9'd88, 16'd0, 1'b0);
		// restart an approach during a turn, then a turn during an approach
		send_request(FUNC_TURN, 9'd10, 16'd0, 1'b0);
		send_request(FUNC_APPROACH, 9'd10, 16'hFFFF, 1'b1);
		send_request(FUNC_SAMPLE, 9'd200, 16'd0, 1'b0);
		send_request(FUNC_TURN, 9'd200, 16'd0, 1'b0);
		send_request(FUNC_SAMPLE, 9'd359, 16'd0, 1'b0);
		send_request(FUNC_SAMPLE, 9'd20, 16'd0, 1'b0);
		send_request(FUNC_SAMPLE, 9'd20, 16'd0, 1'b0);
		drain();
		program_regs(-359, 90, 0, 0, 1, -359);
		// heading correction both ways, then a turn that wraps below zero
		send_request(FUNC_APPROACH, 9'd0, 16'd1, 1'b1);
		send_request(FUNC_SAMPLE, 9'h1FF, 16'd1, 1'b0);
		send_request(FUNC_SAMPLE, 9'd199, 16'd1, 1'b0);
		send_request(FUNC_SAMPLE, 9'd199, 16'd0, 1'b1);
		send_request(FUNC_TURN, 9'd100, 16'd0, 1'b0);
		send_request(FUNC_SAMPLE, 9'd102, 16'd0, 1'b0);
		send_request(FUNC_SAMPLE, 9'd102, 16'd0, 1'b0);
		drain();
		program_regs(359, 0, 65535, 4095, 0, 0);
		// zero turn is reached at once
		send_request(FUNC_TURN, 9'd5, 16'd0, 1'b0);
		send_request(FUNC_SAMPLE, 9'd5, 16'd0, 1'b0);
	endtask

	task automatic run_approach();
		int dist_now;
		int gap;
		int steps;
		logic [1:0] fn;
		dist_now = $urandom_range(65535);
		send_request(FUNC_APPROACH, rand_raw(), 16'(dist_now), 1'b1);
		steps = 0;
		while (sb.run_mode == MODE_APPROACH && steps < 40) begin
			gap = sb.dist_target - dist_now;
			if ($urandom_range(4) == 0) begin
				dist_now = dist_now + gap + int'($urandom_range(2 * sb.dist_band + 2))
					- sb.dist_band - 1;
			end else begin
				dist_now = dist_now + gap - gap / 2;
			end
			if (dist_now < 0) begin
				dist_now = 0;
			end else if (dist_now > 65535) begin
				dist_now = 65535;
			end
			fn = ($urandom_range(19) == 0) ? 2'($urandom_range(3)) : FUNC_SAMPLE;
			send_request(fn, rand_raw(), 16'(dist_now), 1'($urandom_range(9) != 0));
			steps++;
		end
	endtask

	task automatic run_turn();
		int h_now;
		int d;
		int jitter;
		int raw;
		int steps;
		logic [1:0] fn;
		send_request(FUNC_TURN, rand_raw(), 16'($urandom), 1'($urandom_range(1)));
		h_now = sb.last_heading;
		steps = 0;
		while (sb.run_mode == MODE_TURN && steps < 40) begin
			d = sb.target_heading - h_now;
			if (d > 180) begin
				d -= 360;
			end else if (d < -180) begin
				d += 360;
			end
			jitter = $urandom_range(2);
			if ($urandom_range(9) == 0) begin
				h_now = $urandom_range(359);
			end else if (d > 0) begin
				h_now = sb.wrap_deg(h_now + d / 2 + jitter);
			end else if (d < 0) begin
				h_now = sb.wrap_deg(h_now + d / 2 - jitter);
			end
			// steer the raw reading so the wrapped heading lands where wanted
			raw = sb.wrap_deg(h_now - sb.head_offset);
			if (raw < 152 && $urandom_range(4) == 0) begin
				raw += 360;
			end
			fn = ($urandom_range(19) == 0) ? 2'($urandom_range(3)) : FUNC_SAMPLE;
			send_request(fn, 9'(raw), 16'($urandom), 1'($urandom_range(1)));
			steps++;
		end
	endtask

	// result side: random stalls plus one long counted hold-off
	initial begin
		forever begin
			@(posedge clk);
			if (hold_off) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off = 1'b0;
			end
			out_stall <= (!calm && $urandom_range(99) < 30);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			seen.left_drive = left_drive;
			seen.right_drive = right_drive;
			seen.heading = heading;
			seen.deviation = deviation;
			seen.mode = mode;
			seen.done = done_res;
			sb.check_result(seen);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, idle_cycles);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		int phase_goal;
		int pick;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			drain();
			if (phase == 0) begin
				program_regs(359, 90, 65535, 4095, 1, 359);
			end else if (phase == 1) begin
				program_regs(-359, 0, 0, 0, 0, -359);
			end else begin
				program_regs(int'($urandom_range(718)) - 359, $urandom_range(90),
					$urandom_range(65535),
					($urandom_range(3) == 0) ? $urandom_range(4095) : $urandom_range(64),
					$urandom_range(1),
					($urandom_range(5) == 0) ? 0 : int'($urandom_range(718)) - 359);
			end
			calm = (phase == 4);
			if (phase == 2) begin
				hold_off = 1'b1;
			end
			phase_goal = n_requests + PHASE_REQUESTS;
			while (n_requests < phase_goal) begin
				pick = $urandom_range(99);
				if (pick < 45) begin
					run_approach();
				end else if (pick < 85) begin
					run_turn();
				end else begin
					send_request(2'($urandom_range(3)), 9'($urandom_range(511)), 16'($urandom),
						1'($urandom_range(1)));
				end
			end
		end
		drain();
		repeat (4) @(posedge clk);
		$display("covered %0d requests under %0d register settings, %0d results checked",
			n_requests, n_settings, sb.n_checked);
		$display("%0d approaches or turns ran to the end, %0d mismatching results",
			sb.n_done, sb.n_errors);
		if (sb.n_errors == 0 && sb.pending() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

### sim.f
rtl/hddc_pkg.sv
rtl/hddc_cfg_regs.sv
rtl/hddc_heading.sv
rtl/hddc_ctrl.sv
rtl/heading_distance_drive_controller.sv
sim/tb.sv
